// ===== rtl/bsf_pkg.sv =====
package bsf_pkg;

   localparam int LW     = 32;          // length / stiffness width, Q16.16
   localparam int FRAC   = 30;          // strain fraction bits
   localparam int QW     = LW + FRAC;   // strain magnitude width, Q32.30
   localparam int HW     = QW / 2;      // strain split for the multipliers
   localparam int DW     = 32;          // direction width, Q1.30
   localparam int OW     = 48;          // force component width, Q32.16
   localparam int LIMW   = 31;
   localparam int STEPW  = 32;
   localparam int NDIR   = 3;
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   localparam logic [LIMW-1:0]  LIMIT_RESET = 31'd107374182;
   localparam logic [STEPW-1:0] STEP_RESET  = 32'd42949673;

   // configuration register indexes
   localparam logic CSR_LIMIT = 1'b0;
   localparam logic CSR_STEP  = 1'b1;

   localparam logic [63:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MAG = 64'h0000_8000_0000_0000;

   typedef struct packed {
      logic                     zero;
      logic                     s_neg;
      logic [LW-1:0]            diff;
      logic [LW-1:0]            rest;
      logic [LW-1:0]            k1;
      logic [LW-1:0]            k2;
      logic [NDIR-1:0]          d_neg;
      logic [NDIR-1:0][DW-1:0]  dm;
   } item_type;

   function automatic logic [DW-1:0] dir_mag(input logic [DW-1:0] d);
      dir_mag = d[DW-1] ? DW'(~d + 1'b1) : d;
   endfunction

endpackage

// ===== rtl/bsf_front.sv =====
module bsf_front import bsf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [LW-1:0]  req_cur_length,
   input  logic [LW-1:0]  req_rest_length,
   input  logic [LW-1:0]  req_stiff_low,
   input  logic [LW-1:0]  req_stiff_high,
   input  logic [DW-1:0]  req_dir_x,
   input  logic [DW-1:0]  req_dir_y,
   input  logic [DW-1:0]  req_dir_z,
   input  logic           q_full,
   output logic           push,
   output item_type       push_item
);

   logic     v_ff, v_in;
   item_type itm_ff, itm_in;
   logic     fire;

   always_comb begin
      itm_in.zero     = (req_rest_length == '0);
      itm_in.s_neg    = (req_cur_length < req_rest_length);
      itm_in.diff     = itm_in.s_neg ? req_rest_length - req_cur_length
                                     : req_cur_length - req_rest_length;
      itm_in.rest     = req_rest_length;
      itm_in.k1       = req_stiff_low;
      itm_in.k2       = req_stiff_high;
      itm_in.d_neg    = {req_dir_z[DW-1], req_dir_y[DW-1], req_dir_x[DW-1]};
      itm_in.dm[0]    = dir_mag(req_dir_x);
      itm_in.dm[1]    = dir_mag(req_dir_y);
      itm_in.dm[2]    = dir_mag(req_dir_z);
   end

   assign push      = v_ff && !q_full;
   assign req_ready = !v_ff || !q_full;
   assign fire      = req_valid && req_ready;
   assign v_in      = fire || (v_ff && !push);
   assign push_item = itm_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else v_ff <= v_in;
      if (fire) itm_ff <= itm_in;
   end

endmodule

// ===== rtl/bsf_queue.sv =====
module bsf_queue import bsf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   item_type         mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QAW:0]     cnt_ff, cnt_in;

   assign full       = (cnt_ff == (QAW+1)'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

endmodule

// ===== rtl/bsf_div.sv =====
module bsf_div import bsf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  item_type      in_item,
   output logic          out_valid,
   output item_type      out_item,
   output logic [QW-1:0] out_quo
);

   // restoring divider, one quotient bit per stage: (diff << FRAC) / rest
   logic              v_ff   [QW];
   item_type          itm_ff [QW];
   logic [LW-1:0]     rem_ff [QW];
   logic [QW-1:0]     quo_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      localparam int Bit = QW - 1 - j;
      localparam int Di  = (Bit >= FRAC) ? Bit - FRAC : 0;
      logic          v_src;
      item_type      it_src;
      logic [LW-1:0] rem_src;
      logic [QW-1:0] quo_src;
      logic          nbit;
      logic [LW:0]   sh;
      logic          ge;

      if (j == 0) begin : g_first
         assign v_src   = in_valid;
         assign it_src  = in_item;
         assign rem_src = '0;
         assign quo_src = '0;
      end else begin : g_next
         assign v_src   = v_ff[j-1];
         assign it_src  = itm_ff[j-1];
         assign rem_src = rem_ff[j-1];
         assign quo_src = quo_ff[j-1];
      end

      if (Bit >= FRAC) begin : g_dbit
         assign nbit = it_src.diff[Di];
      end else begin : g_zbit
         assign nbit = 1'b0;
      end

      assign sh = {rem_src, nbit};
      assign ge = (sh >= {1'b0, it_src.rest});

      always_ff @(posedge clock) begin
         if (reset) v_ff[j] <= 1'b0;
         else if (en) v_ff[j] <= v_src;
         if (en) begin
            itm_ff[j] <= it_src;
            rem_ff[j] <= ge ? LW'(sh - {1'b0, it_src.rest}) : sh[LW-1:0];
            quo_ff[j] <= {quo_src[QW-2:0], ge};
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_item  = itm_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];

endmodule

// ===== rtl/bsf_back.sv =====
module bsf_back import bsf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  item_type         head_item,
   output logic             pop,
   input  logic [LIMW-1:0]  strain_limit,
   input  logic [STEPW-1:0] time_step,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [OW-1:0]    rsp_force_x,
   output logic [OW-1:0]    rsp_force_y,
   output logic [OW-1:0]    rsp_force_z,
   output logic             rsp_zero_rest,
   output logic             rsp_saturated
);

   logic          en;
   logic          dv;
   item_type      ditm;
   logic [QW-1:0] dq;

   logic [7:0]    vld_ff;
   item_type      it1_ff, it2_ff, it3_ff, it4_ff, it5_ff, it6_ff, it7_ff, it8_ff;

   logic [QW-1:0]      a1_ff, b1_ff;
   logic [LW+HW-1:0]   p1_ff, p2_ff, p3_ff, p4_ff;
   logic [63:0]        slo_ff, shi_ff;
   logic [94:0]        f4;
   logic [63:0]        fq_ff;
   logic               c4_ff, c5_ff, c6_ff, c7_ff, c8_ff;
   logic [63:0]        tlo_ff, thi_ff, tq_ff;
   logic [63:0]        plo_ff [NDIR];
   logic [63:0]        phi_ff [NDIR];
   logic [63:0]        q8_ff  [NDIR];
   logic [63:0]        q8_in  [NDIR];
   logic               c8_in;
   logic [OW-1:0]      fo_in  [NDIR];
   logic [OW-1:0]      fo_ff  [NDIR];
   logic               sat_in, rv_ff, zr_ff, sat_ff;
   logic               le;

   assign en  = !rv_ff || rsp_ready;
   assign pop = en && head_valid;

   bsf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (head_valid),
      .in_item   (head_item),
      .out_valid (dv),
      .out_item  (ditm),
      .out_quo   (dq)
   );

   assign le = (dq <= QW'(strain_limit));
   assign f4 = 95'(slo_ff) + (95'(shi_ff) << HW);

   always_comb begin
      logic [95:0] prod;
      logic        neg;
      c8_in = c7_ff;
      for (int i = 0; i < NDIR; i++) begin
         prod = 96'(plo_ff[i]) + (96'(phi_ff[i]) << 32);
         if (prod[95:94] != 2'b00) begin
            q8_in[i] = '1;
            c8_in    = 1'b1;
         end else begin
            q8_in[i] = prod[93:30];
         end
      end
      sat_in = c8_ff;
      for (int i = 0; i < NDIR; i++) begin
         neg = it8_ff.s_neg ^ it8_ff.d_neg[i];
         if (neg) begin
            if (q8_ff[i] > NEG_MAG) begin
               fo_in[i] = NEG_MAG[OW-1:0];
               sat_in   = 1'b1;
            end else begin
               fo_in[i] = OW'(~q8_ff[i][OW-1:0] + 1'b1);
            end
         end else begin
            if (q8_ff[i] > POS_MAX) begin
               fo_in[i] = POS_MAX[OW-1:0];
               sat_in   = 1'b1;
            end else begin
               fo_in[i] = q8_ff[i][OW-1:0];
            end
         end
         if (it8_ff.zero) fo_in[i] = '0;
      end
      if (it8_ff.zero) sat_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rv_ff  <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:0], dv};
         rv_ff  <= vld_ff[7];
      end
      if (en) begin
         // limit select
         it1_ff <= ditm;
         a1_ff  <= le ? dq : QW'(strain_limit);
         b1_ff  <= le ? '0 : dq - QW'(strain_limit);
         // partial products
         it2_ff <= it1_ff;
         p1_ff  <= (LW+HW)'(it1_ff.k1) * (LW+HW)'(a1_ff[HW-1:0]);
         p2_ff  <= (LW+HW)'(it1_ff.k1) * (LW+HW)'(a1_ff[QW-1:HW]);
         p3_ff  <= (LW+HW)'(it1_ff.k2) * (LW+HW)'(b1_ff[HW-1:0]);
         p4_ff  <= (LW+HW)'(it1_ff.k2) * (LW+HW)'(b1_ff[QW-1:HW]);
         it3_ff <= it2_ff;
         slo_ff <= 64'(p1_ff) + 64'(p3_ff);
         shi_ff <= 64'(p2_ff) + 64'(p4_ff);
         // force in Q48.16
         it4_ff <= it3_ff;
         c4_ff  <= f4[94];
         fq_ff  <= f4[94] ? '1 : f4[93:30];
         // time step
         it5_ff <= it4_ff;
         c5_ff  <= c4_ff;
         tlo_ff <= 64'(fq_ff[31:0]) * 64'(time_step);
         thi_ff <= 64'(fq_ff[63:32]) * 64'(time_step);
         it6_ff <= it5_ff;
         c6_ff  <= c5_ff;
         tq_ff  <= thi_ff + (tlo_ff >> 32);
         // direction products
         it7_ff <= it6_ff;
         c7_ff  <= c6_ff;
         for (int i = 0; i < NDIR; i++) begin
            plo_ff[i] <= 64'(tq_ff[31:0]) * 64'(it6_ff.dm[i]);
            phi_ff[i] <= 64'(tq_ff[63:32]) * 64'(it6_ff.dm[i]);
         end
         it8_ff <= it7_ff;
         c8_ff  <= c8_in;
         for (int i = 0; i < NDIR; i++) q8_ff[i] <= q8_in[i];
         // output register
         for (int i = 0; i < NDIR; i++) fo_ff[i] <= fo_in[i];
         zr_ff  <= it8_ff.zero;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_force_x   = fo_ff[0];
   assign rsp_force_y   = fo_ff[1];
   assign rsp_force_z   = fo_ff[2];
   assign rsp_zero_rest = zr_ff;
   assign rsp_saturated = sat_ff;

endmodule

// ===== rtl/bilinear_spring_force.sv =====
// Bilinear spring force increment, one spring per request.
// Request channel (req_valid/req_ready): lengths, stiffnesses and unit
// direction of one spring. Response channel (rsp_valid/rsp_ready): the
// saturated Q32.16 increment for the first end plus zero_rest/saturated.
// csr_we/csr_index/csr_wdata write strain_limit (0) and time_step (1);
// write only while no request is in flight.
// From the accepting edge to rsp_valid a spring passes the input register,
// queue write, 62-stage strain divider and 9 multiply/saturate stages.
// Throughput: one spring per cycle while rsp_ready is high; the pipelined
// divider and the split multipliers take a new spring every cycle.
// Reset (synchronous, active high) empties the pipeline and restores the
// register defaults; no clearing pass.
// When rsp_ready is low the back pipeline freezes with its result held;
// the front keeps taking requests into the 4-entry queue until it fills.
module bilinear_spring_force import bsf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [STEPW-1:0]  csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [LW-1:0]     req_cur_length,
   input  logic [LW-1:0]     req_rest_length,
   input  logic [LW-1:0]     req_stiff_low,
   input  logic [LW-1:0]     req_stiff_high,
   input  logic [DW-1:0]     req_dir_x,
   input  logic [DW-1:0]     req_dir_y,
   input  logic [DW-1:0]     req_dir_z,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OW-1:0]     rsp_force_x,
   output logic [OW-1:0]     rsp_force_y,
   output logic [OW-1:0]     rsp_force_z,
   output logic              rsp_zero_rest,
   output logic              rsp_saturated
);

   logic [LIMW-1:0]  limit_ff;
   logic [STEPW-1:0] step_ff;

   logic     q_full, push, pop, head_valid;
   item_type push_item, head_item;

   // config registers; upper data bits beyond a register's width dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         step_ff  <= STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIMIT: limit_ff <= csr_wdata[LIMW-1:0];
            CSR_STEP:  step_ff  <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // front: registers the request, sign, |cur - rest|, direction magnitudes
   bsf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cur_length  (req_cur_length),
      .req_rest_length (req_rest_length),
      .req_stiff_low   (req_stiff_low),
      .req_stiff_high  (req_stiff_high),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .q_full          (q_full),
      .push            (push),
      .push_item       (push_item)
   );

   // decoupling queue
   bsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // back: divider, bilinear force, step and direction scaling, clipping
   bsf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .strain_limit  (limit_ff),
      .time_step     (step_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_force_x   (rsp_force_x),
      .rsp_force_y   (rsp_force_y),
      .rsp_force_z   (rsp_force_z),
      .rsp_zero_rest (rsp_zero_rest),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ===== rtl/bsf_checker.sv =====
module bsf_checker import bsf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              csr_we,
   input logic              req_valid,
   input logic              req_ready,
   input logic [LW-1:0]     req_cur_length,
   input logic [LW-1:0]     req_rest_length,
   input logic [LW-1:0]     req_stiff_low,
   input logic [LW-1:0]     req_stiff_high,
   input logic [DW-1:0]     req_dir_x,
   input logic [DW-1:0]     req_dir_y,
   input logic [DW-1:0]     req_dir_z,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [OW-1:0]     rsp_force_x,
   input logic [OW-1:0]     rsp_force_y,
   input logic [OW-1:0]     rsp_force_z,
   input logic              rsp_zero_rest,
   input logic              rsp_saturated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_force_x)
         && $stable(rsp_force_y) && $stable(rsp_force_z)
         && $stable(rsp_zero_rest) && $stable(rsp_saturated))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_zero_rest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_rest |-> rsp_force_x == '0 && rsp_force_y == '0
         && rsp_force_z == '0 && !rsp_saturated)
      else $error("zero rest length with nonzero force");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_cur_length)
         && $stable(req_rest_length) && $stable(req_stiff_low)
         && $stable(req_stiff_high) && $stable(req_dir_x)
         && $stable(req_dir_y) && $stable(req_dir_z))
      else $error("request dropped or changed while waiting");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_we |-> !rsp_valid && !req_valid)
      else $error("register write with traffic in flight");

endmodule

bind bilinear_spring_force bsf_checker u_bsf_checker (.*);

// ===== bench/bilinear_spring_force_tb.sv =====
module bilinear_spring_force_tb import bsf_pkg::*; ();

   // Clock and reset; reset is held at the start only.
   logic clock;
   logic reset;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Configuration write port.
   logic              csr_we;
   logic              csr_index;
   logic [STEPW-1:0]  csr_wdata;

   // Request channel.
   logic              req_valid;
   logic              req_ready;
   logic [LW-1:0]     req_cur_length;
   logic [LW-1:0]     req_rest_length;
   logic [LW-1:0]     req_stiff_low;
   logic [LW-1:0]     req_stiff_high;
   logic [DW-1:0]     req_dir_x;
   logic [DW-1:0]     req_dir_y;
   logic [DW-1:0]     req_dir_z;

   // Response channel.
   logic              rsp_valid;
   logic              rsp_ready;
   logic [OW-1:0]     rsp_force_x;
   logic [OW-1:0]     rsp_force_y;
   logic [OW-1:0]     rsp_force_z;
   logic              rsp_zero_rest;
   logic              rsp_saturated;

   bilinear_spring_force uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cur_length  (req_cur_length),
      .req_rest_length (req_rest_length),
      .req_stiff_low   (req_stiff_low),
      .req_stiff_high  (req_stiff_high),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_force_x     (rsp_force_x),
      .rsp_force_y     (rsp_force_y),
      .rsp_force_z     (rsp_force_z),
      .rsp_zero_rest   (rsp_zero_rest),
      .rsp_saturated   (rsp_saturated)
   );

   // One spring as it goes into the block.
   typedef struct {
      logic [LW-1:0] cur;
      logic [LW-1:0] rest;
      logic [LW-1:0] k1;
      logic [LW-1:0] k2;
      logic [DW-1:0] dx;
      logic [DW-1:0] dy;
      logic [DW-1:0] dz;
   } spring_type;

   // One increment as it comes out.
   typedef struct packed {
      logic [OW-1:0] fx;
      logic [OW-1:0] fy;
      logic [OW-1:0] fz;
      logic          zr;
      logic          sat;
   } incr_type;

   localparam int LATENCY   = 80;
   localparam int N_RANDOM  = 1330;
   localparam int MAX_CYC   = 400000;

   // Shadow copies of the two registers, used by the force predictor.
   logic [LIMW-1:0]  lim_shadow;
   logic [STEPW-1:0] step_shadow;

   incr_type pending_incr[$];
   int       n_fail;
   int       cycle_count;

   // Drop 30 fraction bits from a 128-bit magnitude, clipping to 64 bits.
   function automatic logic [63:0] drop30(input logic [127:0] x, inout logic clip);
      if (x[127:94] != 0) begin
         clip = 1'b1;
         return '1;
      end
      return x[93:30];
   endfunction

   // Predicted first-end increment of one spring.
   function automatic incr_type spring_incr(input spring_type s);
      incr_type       r;
      logic           clip;
      logic           s_neg;
      logic [63:0]    diff, mag, fq, tq, q;
      logic [127:0]   f, t;
      logic [DW-1:0]  d [3];
      logic [OW-1:0]  v [3];
      logic           dn;
      logic [63:0]    dm;
      r = '{default: '0};
      if (s.rest == 0) begin
         r.zr = 1'b1;
         return r;
      end
      clip  = 1'b0;
      s_neg = s.cur < s.rest;
      diff  = s_neg ? 64'(s.rest - s.cur) : 64'(s.cur - s.rest);
      mag   = (diff << 30) / 64'(s.rest);
      if (mag <= 64'(lim_shadow))
         f = 128'(s.k1) * 128'(mag);
      else
         f = 128'(s.k1) * 128'(lim_shadow)
           + 128'(s.k2) * 128'(mag - 64'(lim_shadow));
      fq = drop30(f, clip);
      t  = 128'(fq) * 128'(step_shadow);
      tq = t[95:32];
      d[0] = s.dx; d[1] = s.dy; d[2] = s.dz;
      for (int i = 0; i < 3; i++) begin
         dn = d[i][DW-1];
         dm = dn ? 64'(33'h1_0000_0000 - 33'(d[i])) : 64'(d[i]);
         q  = drop30(128'(tq) * 128'(dm), clip);
         if (s_neg != dn) begin
            if (q > NEG_MAG) begin
               q = NEG_MAG;
               clip = 1'b1;
            end
            v[i] = OW'(~q + 1);
         end else begin
            if (q > POS_MAX) begin
               q = POS_MAX;
               clip = 1'b1;
            end
            v[i] = OW'(q);
         end
      end
      r.fx = v[0]; r.fy = v[1]; r.fz = v[2];
      r.sat = clip;
      return r;
   endfunction

   // Directed table: a row with a known increment carries it typed in.
   typedef struct {
      spring_type s;
      logic       typed;
      incr_type   want;
   } row_type;

   localparam logic [31:0] ONE = 32'h4000_0000;   // 1.0 in Q1.30
   localparam logic [31:0] MONE = 32'hC000_0000;  // -1.0

   row_type dir_rows[$];

   task automatic add_row(input logic [31:0] c, r, k1, k2, dx, dy, dz,
                          input logic typed = 1'b0,
                          input incr_type want = '0);
      row_type row;
      row.s = '{c, r, k1, k2, dx, dy, dz};
      row.typed = typed;
      row.want = want;
      dir_rows.push_back(row);
   endtask

   task automatic csr_write(input logic idx, input logic [STEPW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      if (idx == CSR_LIMIT)
         lim_shadow = val[LIMW-1:0];
      else
         step_shadow = val;
   endtask

   // Let the pipeline drain before a register write.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_incr.size() != 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // Present one request and hold it until accepted; requests come in bursts with gaps between.
   int burst_left;

   task automatic send_spring(input spring_type s);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_cur_length  <= s.cur;
      req_rest_length <= s.rest;
      req_stiff_low   <= s.k1;
      req_stiff_high  <= s.k2;
      req_dir_x       <= s.dx;
      req_dir_y       <= s.dy;
      req_dir_z       <= s.dz;
      do
         @(posedge clock);
      while (!req_ready);
      // Accepted at this edge; the expectation is queued in the same step.
      pending_incr.push_back(spring_incr(s));
   endtask

   // Random direction: mostly in range, sometimes any 32-bit pattern.
   function automatic logic [31:0] rand_dir();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return ONE;
         2:       return MONE;
         default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
      endcase
   endfunction

   function automatic spring_type rand_spring();
      spring_type s;
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: s.rest = 0;
         1: s.rest = $urandom();
         default: s.rest = $urandom_range(32'h0000_4000, 32'h0100_0000);
      endcase
      // Current length near rest so that both sides of the limit are hit.
      case ($urandom_range(0, 5))
         0: s.cur = $urandom();
         1: s.cur = s.rest;
         default: s.cur = s.rest + 32'($signed(r) >>> $urandom_range(4, 31));
      endcase
      s.k1 = $urandom_range(0, 3) == 0 ? $urandom() : $urandom() >> $urandom_range(0, 24);
      s.k2 = $urandom_range(0, 3) == 0 ? $urandom() : $urandom() >> $urandom_range(0, 24);
      s.dx = rand_dir();
      s.dy = rand_dir();
      s.dz = rand_dir();
      return s;
   endfunction

   // Receiver: stalls on its own pattern, with long stall-free stretches.
   int stall_phase;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 256;
         if (stall_phase < 64)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Response checker: compare each response with the oldest expectation.
   always @(posedge clock) begin
      incr_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_incr.size() == 0) begin
            $display("%0t unexpected response fx=%h", $time, rsp_force_x);
            n_fail++;
         end else begin
            want = pending_incr.pop_front();
            if (rsp_force_x !== want.fx) begin
               $display("%0t force_x exp %h got %h", $time, want.fx, rsp_force_x);
               n_fail++;
            end
            if (rsp_force_y !== want.fy) begin
               $display("%0t force_y exp %h got %h", $time, want.fy, rsp_force_y);
               n_fail++;
            end
            if (rsp_force_z !== want.fz) begin
               $display("%0t force_z exp %h got %h", $time, want.fz, rsp_force_z);
               n_fail++;
            end
            if (rsp_zero_rest !== want.zr) begin
               $display("%0t zero_rest exp %b got %b", $time, want.zr, rsp_zero_rest);
               n_fail++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t saturated exp %b got %b", $time, want.sat, rsp_saturated);
               n_fail++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYC) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      row_type  row;
      incr_type zr_incr;
      logic [STEPW-1:0] steps [4];
      logic [STEPW-1:0] lims  [4];
      n_fail = 0;
      cycle_count = 0;
      burst_left = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_LIMIT;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_cur_length = '0;
      req_rest_length = '0;
      req_stiff_low = '0;
      req_stiff_high = '0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_dir_z = '0;
      lim_shadow = LIMIT_RESET;
      step_shadow = STEP_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, run at the reset register values.
      zr_incr = '{default: '0};
      zr_incr.zr = 1'b1;
      // zero rest length: flag set, force zero
      add_row(32'h0001_0000, 32'h0, '1, '1, ONE, MONE, ONE, 1'b1, zr_incr);
      add_row('1, 32'h0, '1, '1, '1, '1, '1, 1'b1, zr_incr);
      // zero strain: no force whatever the stiffness
      add_row(32'h0001_0000, 32'h0001_0000, '1, '1, ONE, MONE, ONE,
              1'b1, '{default: '0});
      // zero stiffness: no force
      add_row(32'h0002_0000, 32'h0001_0000, 0, 0, ONE, ONE, ONE,
              1'b1, '{default: '0});
      // zero direction
      add_row(32'h0002_0000, 32'h0001_0000, '1, '1, 0, 0, 0,
              1'b1, '{default: '0});
      // small strain inside the limit, stretched and compressed
      add_row(32'h0001_0400, 32'h0001_0000, 32'h0064_0000, 32'h0320_0000,
              ONE, MONE, 32'h2000_0000);
      add_row(32'h0000_FC00, 32'h0001_0000, 32'h0064_0000, 32'h0320_0000,
              ONE, MONE, 32'h2000_0000);
      // strain exactly at the 0.1 limit region and beyond it
      add_row(32'h0001_199A, 32'h0001_0000, 32'h0064_0000, 32'h0320_0000,
              ONE, ONE, ONE);
      add_row(32'h0001_8000, 32'h0001_0000, 32'h0064_0000, 32'h0320_0000,
              MONE, ONE, MONE);
      add_row(32'h0000_4000, 32'h0001_0000, 32'h0064_0000, 32'h0320_0000,
              ONE, MONE, ONE);
      // fully compressed, huge stretch, extreme fields
      add_row(0, '1, '1, '1, ONE, MONE, ONE);
      add_row('1, 32'h0000_0001, '1, '1, ONE, MONE, ONE);
      add_row('1, 32'h0000_0001, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF, '1);
      add_row(32'h0000_0001, '1, 32'h0000_0001, 32'h0000_0001, 32'h8000_0000, 1, '1);
      // direction outside the unit range
      add_row(32'h0010_0000, 32'h0001_0000, 32'h1000_0000, 32'h1000_0000,
              32'h7FFF_FFFF, 32'h8000_0001, 32'h5555_5555);
      add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
              32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_spring(row.s);
         // The predictor must agree with the typed-in increment.
         if (row.typed && pending_incr[$] != row.want) begin
            $display("%0t directed row %0d exp %h got %h", $time, i,
                     row.want.fx, pending_incr[$].fx);
            n_fail++;
         end
      end

      // Random part over several register settings, extremes included.
      lims[0] = 0; lims[1] = 32'h7FFF_FFFF; lims[2] = 32'hFFFF_FFFF; lims[3] = 0;
      steps[0] = '1; steps[1] = 0; steps[2] = 32'h8000_0000; steps[3] = 0;
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         if (ph < 4) begin
            lims[3] = $urandom_range(0, 32'h4000_0000);
            steps[3] = $urandom();
            csr_write(CSR_LIMIT, lims[ph]);
            csr_write(CSR_STEP, steps[ph]);
         end else begin
            csr_write(CSR_LIMIT, 32'(LIMIT_RESET));
            csr_write(CSR_STEP, STEP_RESET);
         end
         for (int n = 0; n < N_RANDOM / 5; n++)
            send_spring(rand_spring());
      end

      drain();
      if (n_fail == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
